// ----- src/biquad_filter_with_stability_guard_core_macros.svh -----
// Assertion macros shared by the biquad checker.
`ifndef BIQUAD_FILTER_WITH_STABILITY_GUARD_CORE_MACROS_SVH
`define BIQUAD_FILTER_WITH_STABILITY_GUARD_CORE_MACROS_SVH

// Implication checked in the same cycle.
`define BQSG_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Implication checked in the next cycle.
`define BQSG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- src/bqsg_pkg.sv -----
// Shared types and constants for the biquad filter with stability guard.
`timescale 1ns / 1ps

package bqsg_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 24;
   localparam int STATE_W   = 32;
   localparam int FRAC_W    = 20;
   // accumulator head of the serial MAC: three coefficient terms plus growth
   localparam int ACC_W     = COEF_W + 3;
   localparam int PROD_W    = ACC_W + STATE_W;
   localparam int CNT_W     = $clog2(STATE_W);
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_ONE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_TWO = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_ZERO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_ONE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_TWO  = 3'd4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [STATE_W-1:0]  delay_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   // operands of one serial multiply-accumulate pass
   typedef struct packed {
      coef_type  coef_a;
      coef_type  coef_b;
      coef_type  coef_c;
      delay_type mcand_a;
      delay_type mcand_b;
      delay_type mcand_c;
   } mac_op_type;

endpackage

// ----- src/bqsg_mac.sv -----
// Bit-serial three-term multiply-accumulate, one multiplicand bit per cycle.
`timescale 1ns / 1ps

module bqsg_mac import bqsg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  mac_op_type op,
   output logic       done,
   output prod_type   prod
);

   logic                    busy_ff;
   logic                    done_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [STATE_W-1:0]      sh_a_ff, sh_b_ff, sh_c_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [STATE_W-1:0]      low_ff;

   logic                    last;
   logic signed [ACC_W-1:0] sum_in;

   // one partial product term; the sign bit of the multiplicand weighs negative
   function automatic logic signed [ACC_W-1:0] term(coef_type c, logic bit_v, logic neg);
      logic signed [ACC_W-1:0] ext;
      ext = ACC_W'(c);
      if (!bit_v) return '0;
      return neg ? -ext : ext;
   endfunction

   assign last = (cnt_ff == CNT_W'(STATE_W - 1));

   // add the three terms for the current bit
   always_comb begin
      sum_in = acc_ff + term(op.coef_a, sh_a_ff[0], last)
                      + term(op.coef_b, sh_b_ff[0], last)
                      + term(op.coef_c, sh_c_ff[0], last);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) busy_ff <= 1'b0;
         end
      end
   end

   // datapath: right-shifting product, low bits drop into low_ff
   always_ff @(posedge clock) begin
      if (start) begin
         sh_a_ff <= op.mcand_a;
         sh_b_ff <= op.mcand_b;
         sh_c_ff <= op.mcand_c;
         acc_ff  <= '0;
         low_ff  <= '0;
      end else if (busy_ff) begin
         sh_a_ff <= sh_a_ff >> 1;
         sh_b_ff <= sh_b_ff >> 1;
         sh_c_ff <= sh_c_ff >> 1;
         acc_ff  <= sum_in >>> 1;
         low_ff  <= {sum_in[0], low_ff[STATE_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = {acc_ff, low_ff};

endmodule

// ----- src/bqsg_guard.sv -----
// Stability check of the feedback pair against the triangle and pole bound.
`timescale 1ns / 1ps

module bqsg_guard import bqsg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  coef_type feedback_one,
   input  coef_type feedback_two,
   output logic     stable
);

   localparam int SQ_W   = 2 * COEF_W;
   localparam int DISC_W = SQ_W + 1;
   localparam int GW     = COEF_W + 2;
   localparam int ONE_I  = 1 << FRAC_W;

   logic signed [SQ_W-1:0]   sq_ff;
   coef_type                 a_ff, b_ff;
   logic                     stable_ff;

   logic signed [DISC_W-1:0] disc;
   logic signed [GW-1:0]     ext_a, ext_b, tri_lo, tri_hi;
   logic                     stable_in;

   // stage 1: square of the first coefficient
   always_ff @(posedge clock) begin
      sq_ff <= SQ_W'(feedback_one) * SQ_W'(feedback_one);
      a_ff  <= feedback_one;
      b_ff  <= feedback_two;
   end

   // stage 2: discriminant sign and the bounds
   always_comb begin
      ext_a  = GW'(a_ff);
      ext_b  = GW'(b_ff);
      disc   = DISC_W'(sq_ff) + (DISC_W'(b_ff) <<< (FRAC_W + 2));
      tri_lo = GW'(ONE_I) - ext_a - ext_b;
      tri_hi = GW'(ONE_I) + ext_a - ext_b;
      if (disc < 0) begin
         stable_in = (ext_b >= -GW'(ONE_I));
      end else begin
         stable_in = (ext_a <= GW'(2 * ONE_I)) && (ext_a >= -GW'(2 * ONE_I)) &&
                     (tri_lo >= 0) && (tri_hi >= 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) stable_ff <= 1'b1;
      else       stable_ff <= stable_in;
   end

   assign stable = stable_ff;

endmodule

// ----- src/biquad_filter_with_stability_guard_core.sv -----
// Top level of the biquad IIR filter (direct form II) with stability guard.
// Usage:
//  - csr_ channel writes one coefficient word (index 0..4, Q4.20) per accept;
//    csr_ready is always high. Write only while no sample is in flight.
//    Indexes beyond four are ignored.
//  - req_ channel takes one 24-bit sample word; rsp_ channel returns one
//    filtered, saturated 24-bit word per sample.
//  - Each sample runs two bit-serial passes of a shared three-term MAC, one
//    multiplicand bit per cycle: first the feedback sum, then the output
//    sum, plus rounding and handoff.
//  - rsp_valid rises when the result is handed to the output register;
//    req_ready returns in the same cycle, so a sample is taken only after the last one is handed off.
//  - The result sits in an output register, so the next sample is taken
//    while rsp_valid still waits; a stalled receiver only blocks the next
//    result handoff, which then waits until rsp_ready.
//  - If the feedback pair is unstable, the output is 0 and the delay line
//    takes the raw sample.
//  - Synchronous active-high reset clears coefficients, delay line and
//    handshakes; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module biquad_filter_with_stability_guard_core import bqsg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [SAMPLE_W-1:0]  req_sample_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SAMPLE_W-1:0]  rsp_sample_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data
);

   localparam int HI_W  = PROD_W - FRAC_W;
   localparam int SUM_W = HI_W + 2;
   localparam logic signed [SUM_W-1:0] W_HI =
      {{(SUM_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] W_LO = ~W_HI;
   localparam logic signed [SUM_W-1:0] Y_HI =
      {{(SUM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] Y_LO = ~Y_HI;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS1,
      ST_FIN1,
      ST_PASS2,
      ST_OUT
   } state_type;

   state_type  state_ff;
   coef_type   fb1_ff, fb2_ff, fw0_ff, fw1_ff, fw2_ff;
   delay_type  dn_ff, do_ff, w_ff;
   sample_type x_ff, y_ff, rsp_data_ff;
   logic       rsp_valid_ff;

   logic       stable;
   logic       mac_start, mac_done, pass2;
   mac_op_type mac_op;
   prod_type   prod;

   logic signed [HI_W-1:0]  prod_hi;
   logic signed [SUM_W-1:0] sum_in;
   delay_type               w_in;
   sample_type              y_in;
   logic                    req_take, rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fb1_ff <= '0;
         fb2_ff <= '0;
         fw0_ff <= '0;
         fw1_ff <= '0;
         fw2_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FEEDBACK_ONE: fb1_ff <= csr_data;
            CSR_FEEDBACK_TWO: fb2_ff <= csr_data;
            CSR_FORWARD_ZERO: fw0_ff <= csr_data;
            CSR_FORWARD_ONE:  fw1_ff <= csr_data;
            CSR_FORWARD_TWO:  fw2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   bqsg_guard u_guard (
      .clock        (clock),
      .reset        (reset),
      .feedback_one (fb1_ff),
      .feedback_two (fb2_ff),
      .stable       (stable)
   );

   // MAC operands: feedback pair first, then the three forward taps
   assign pass2     = (state_ff == ST_FIN1) || (state_ff == ST_PASS2);
   assign mac_start = req_take || (state_ff == ST_FIN1);

   always_comb begin
      mac_op.coef_a  = pass2 ? fw1_ff : fb1_ff;
      mac_op.coef_b  = pass2 ? fw2_ff : fb2_ff;
      mac_op.coef_c  = pass2 ? fw0_ff : '0;
      mac_op.mcand_a = dn_ff;
      mac_op.mcand_b = do_ff;
      mac_op.mcand_c = w_ff;
   end

   bqsg_mac u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .op    (mac_op),
      .done  (mac_done),
      .prod  (prod)
   );

   // round half up, add the sample on the feedback pass, saturate
   always_comb begin
      prod_hi = prod[PROD_W-1:FRAC_W];
      sum_in  = SUM_W'(prod_hi) + SUM_W'({1'b0, prod[FRAC_W-1]});
      if (state_ff == ST_PASS1) sum_in = sum_in + SUM_W'(x_ff);

      if (!stable)           w_in = STATE_W'(x_ff);
      else if (sum_in > W_HI) w_in = W_HI[STATE_W-1:0];
      else if (sum_in < W_LO) w_in = W_LO[STATE_W-1:0];
      else                    w_in = sum_in[STATE_W-1:0];

      if (!stable)           y_in = '0;
      else if (sum_in > Y_HI) y_in = Y_HI[SAMPLE_W-1:0];
      else if (sum_in < Y_LO) y_in = Y_LO[SAMPLE_W-1:0];
      else                    y_in = sum_in[SAMPLE_W-1:0];
   end

   // sequencer, delay line and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dn_ff        <= '0;
         do_ff        <= '0;
      end else begin
         // result word: load on handoff, clear once taken
         if (state_ff == ST_OUT && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  x_ff     <= req_sample_in;
                  state_ff <= ST_PASS1;
               end
            end
            ST_PASS1: begin
               if (mac_done) begin
                  w_ff     <= w_in;
                  state_ff <= ST_FIN1;
               end
            end
            ST_FIN1: begin
               state_ff <= ST_PASS2;
            end
            ST_PASS2: begin
               if (mac_done) begin
                  y_ff     <= y_in;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_data_ff  <= y_ff;
                  do_ff        <= dn_ff;
                  dn_ff        <= w_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

// ----- src/bqsg_checker.sv -----
// Port-level checker for the biquad core and its bind.
`timescale 1ns / 1ps
`include "biquad_filter_with_stability_guard_core_macros.svh"

module bqsg_checker import bqsg_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_sample_out
);

   // a held result word stays put
   `BQSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped")
   `BQSG_ASSERT_NEXT(a_rsp_data, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_sample_out), "rsp word changed")

   // one sample at a time: ready falls right after an accept
   `BQSG_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "second sample accepted")

   // a new result only comes out of the busy phase
   `BQSG_ASSERT_SAME(a_rsp_src, clock, reset, $rose(rsp_valid), $past(!req_ready), "result while idle")

endmodule

bind biquad_filter_with_stability_guard_core bqsg_checker u_bqsg_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for the biquad IIR filter with stability guard.
`timescale 1ns / 1ps

module testbench import bqsg_pkg::*; ();

   localparam int     CYCLE_LIMIT = 1_000_000;
   localparam int     HOLD_CYCLES = 400;
   localparam int     SEGMENTS    = 18;
   localparam int     SEG_ITEMS   = 100;
   localparam int     MAX_PRINTS  = 40;
   localparam int     ONE_I       = 1 << FRAC_W;
   localparam longint ONE_Q       = longint'(1) <<< FRAC_W;
   localparam longint HALF_Q      = ONE_Q >>> 1;
   localparam longint W_HI        = (longint'(1) <<< (STATE_W - 1)) - 1;
   localparam longint W_LO        = -W_HI - 1;
   localparam longint Y_HI        = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint Y_LO        = -Y_HI - 1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP = '1;

   // Filter predictor plus pending-sample queue
   class biquad_scoreboard;
      longint     fb_one, fb_two, fwd_zero, fwd_one, fwd_two;
      longint     delay_newest, delay_older;
      sample_type expected_samples[$];
      int         errors;

      function new();
         fb_one = 0; fb_two = 0; fwd_zero = 0; fwd_one = 0; fwd_two = 0;
         delay_newest = 0; delay_older = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
         coef_type c;
         c = data;
         case (idx)
            CSR_FEEDBACK_ONE: fb_one   = longint'(c);
            CSR_FEEDBACK_TWO: fb_two   = longint'(c);
            CSR_FORWARD_ZERO: fwd_zero = longint'(c);
            CSR_FORWARD_ONE:  fwd_one  = longint'(c);
            CSR_FORWARD_TWO:  fwd_two  = longint'(c);
            default: ;
         endcase
      endfunction

      // stability triangle plus complex-pole bound, bounds inclusive
      function bit pair_stable(longint a, longint b);
         longint disc;
         disc = a * a + 4 * b * ONE_Q;
         if (disc < 0) return b >= -ONE_Q;
         return a <= 2 * ONE_Q && a >= -2 * ONE_Q &&
                ONE_Q - a - b >= 0 && ONE_Q + a - b >= 0;
      endfunction

      // round half up from Q.20, then saturate
      function longint round_sat(longint acc, longint lo, longint hi);
         longint r;
         r = (acc + HALF_Q) >>> FRAC_W;
         if (r < lo) return lo;
         if (r > hi) return hi;
         return r;
      endfunction

      function void note_sample(sample_type x);
         longint a, b, f0, f1, f2, w, y;
         a = fb_one; b = fb_two; f0 = fwd_zero; f1 = fwd_one; f2 = fwd_two;
         if (!pair_stable(a, b)) begin
            a = 0; b = 0; f0 = 0; f1 = 0; f2 = 0;
         end
         w = round_sat(longint'(x) * ONE_Q + a * delay_newest + b * delay_older, W_LO, W_HI);
         y = round_sat(f0 * w + f1 * delay_newest + f2 * delay_older, Y_LO, Y_HI);
         delay_older  = delay_newest;
         delay_newest = w;
         expected_samples.push_back(sample_type'(y));
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTS) $display("ERROR: %s", msg);
      endtask

      task check_sample(sample_type got);
         sample_type want;
         if (expected_samples.size() == 0) begin
            report($sformatf("unexpected word sample_out=%0d", got));
         end else begin
            want = expected_samples.pop_front();
            if (got !== want)
               report($sformatf("sample_out got %0d expected %0d", got, want));
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_sample_out;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [COEF_W-1:0]    csr_data      = '0;

   biquad_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_asked   = 0;
   int holds_done    = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   biquad_filter_with_stability_guard_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random stalls, plus long holds on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_sample(rsp_sample_out);
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] x);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(x);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // load all five coefficients; optionally a write to an unused index
   task automatic load_filter(input logic [COEF_W-1:0] fb1, input logic [COEF_W-1:0] fb2,
                              input logic [COEF_W-1:0] f0, input logic [COEF_W-1:0] f1,
                              input logic [COEF_W-1:0] f2, input bit junk);
      int idx;
      write_reg(CSR_FEEDBACK_ONE, fb1);
      write_reg(CSR_FEEDBACK_TWO, fb2);
      write_reg(CSR_FORWARD_ZERO, f0);
      write_reg(CSR_FORWARD_ONE,  f1);
      write_reg(CSR_FORWARD_TWO,  f2);
      if (junk) begin
         idx = int'(CSR_FORWARD_TWO) + 1 +
               $urandom_range(int'(CSR_IDX_TOP) - int'(CSR_FORWARD_TWO) - 1);
         write_reg(idx[CSR_IDX_W-1:0], COEF_W'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (sb.expected_samples.size() != 0) @(posedge clock);
   endtask

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int r;
      r = $urandom_range(99);
      if (r < 70) return SAMPLE_W'($urandom);
      if (r < 85) begin
         case ($urandom_range(3))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return SAMPLE_W'(rand_between(-256, 256));
   endfunction

   // feedback pairs on and just past the stability boundary
   task automatic boundary_pair(input int k, output int a, output int b);
      case (k)
         0: begin a =  2 * ONE_I;     b = -ONE_I;     end
         1: begin a = -2 * ONE_I;     b = -ONE_I;     end
         2: begin a =  0;             b = -ONE_I;     end
         3: begin a =  0;             b = -ONE_I - 1; end
         4: begin a =  2 * ONE_I + 1; b = -ONE_I;     end
         5: begin a =  ONE_I;         b =  0;         end
         6: begin a =  ONE_I;         b =  1;         end
         7: begin a = -ONE_I;         b =  0;         end
         8: begin a =  0;             b =  ONE_I;     end
         9: begin a =  0;             b =  ONE_I + 1; end
         default: begin a = ONE_I;    b = -ONE_I;     end
      endcase
   endtask

   task automatic random_filter();
      int kind, a, b, lim;
      logic [COEF_W-1:0] f0, f1, f2;
      kind = $urandom_range(9);
      // stable pair inside the triangle by construction
      b   = rand_between(-ONE_I, ONE_I);
      lim = ONE_I - b;
      if (lim > 2 * ONE_I) lim = 2 * ONE_I;
      a   = rand_between(-lim, lim);
      f0  = COEF_W'(rand_between(-ONE_I, ONE_I));
      f1  = COEF_W'(rand_between(-ONE_I, ONE_I));
      f2  = COEF_W'(rand_between(-ONE_I, ONE_I));
      if (kind == 5 || kind == 6) begin
         f0 = COEF_W'($urandom); f1 = COEF_W'($urandom); f2 = COEF_W'($urandom);
      end else if (kind == 7) begin
         a = $urandom; b = $urandom;
         f0 = COEF_W'($urandom); f1 = COEF_W'($urandom); f2 = COEF_W'($urandom);
      end else if (kind == 8) begin
         boundary_pair($urandom_range(10), a, b);
      end
      if (kind == 9) begin
         if ($urandom_range(1)) load_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
         else load_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b1);
      end else begin
         load_filter(COEF_W'(a), COEF_W'(b), f0, f1, f2, $urandom_range(99) < 30);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass-through, extremes of the sample
      load_filter('0, '0, COEF_W'(ONE_I), '0, '0, 1'b0);
      push_sample(SAMPLE_MAX); push_sample(SAMPLE_MIN); push_sample('0);
      push_sample('1); push_sample(SAMPLE_W'(1));
      req_valid <= 1'b0;
      drain();

      // all coefficients at max: unstable, output forced to zero
      load_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 1'b0);
      push_sample(SAMPLE_MAX); push_sample('1); push_sample(SAMPLE_MIN);
      req_valid <= 1'b0;
      drain();

      // corner of the triangle (a=2, b=-1) with most negative forward terms
      load_filter(COEF_W'(2 * ONE_I), COEF_W'(-ONE_I), COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
      push_sample(SAMPLE_MAX); push_sample(SAMPLE_MAX); push_sample(SAMPLE_MAX);
      req_valid <= 1'b0;
      drain();

      // one step below b = -1: unstable
      load_filter('0, COEF_W'(-ONE_I - 1), COEF_W'(ONE_I), COEF_W'(ONE_I), COEF_W'(ONE_I),
                  1'b0);
      push_sample(SAMPLE_MIN); push_sample(SAMPLE_MAX);
      req_valid <= 1'b0;
      drain();

      // all coefficients at min, plus a write to an unused index
      load_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 1'b1);
      push_sample(SAMPLE_MAX); push_sample(SAMPLE_MIN);
      req_valid <= 1'b0;
      drain();

      // complex poles on the b = -1 bound
      load_filter(COEF_W'(ONE_I), COEF_W'(-ONE_I), COEF_W'(ONE_I / 2), COEF_W'(ONE_I),
                  COEF_W'(-ONE_I), 1'b1);
      push_sample(SAMPLE_MIN); push_sample(SAMPLE_MIN); push_sample(SAMPLE_MIN);
      req_valid <= 1'b0;
      drain();

      // random segments, one filter setting each
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 0) begin
            send_idle_pct = 29; recv_idle_pct = 62;
         end else if (seg == SEGMENTS / 3) begin
            send_idle_pct = 62; recv_idle_pct = 29;
         end else if (seg == 2 * SEGMENTS / 3) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         random_filter();
         if (seg == 3 || seg == 2 * SEGMENTS / 3) holds_asked++;
         for (int i = 0; i < SEG_ITEMS; i++) push_sample(rand_sample());
         req_valid <= 1'b0;
         drain();
      end

      // settle, then verdict
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
